>>> rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the byte budget admission block: field
// widths, opcodes, configuration register indexes and reset budgets.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W  = 48;
    localparam int COUNT_W = 64;
    localparam int IDX_W   = 6;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 1;

    // Default size of the owner table.
    localparam int OWNER_SLOTS_DEF = 64;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_ACQUIRE    = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE    = 2'd1;
    localparam logic [OP_W-1:0] OP_SPILL      = 2'd2;
    localparam logic [OP_W-1:0] OP_SPILL_FAIL = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] REG_TOTAL_LIMIT  = 1'd0;
    localparam logic [CFG_W-1:0] REG_OWNER_BUDGET = 1'd1;

    // Budgets after reset: 256 MiB in total, 64 MiB per owner.
    localparam logic [BYTE_W-1:0] TOTAL_LIMIT_RST  = BYTE_W'(64'd268435456);
    localparam logic [BYTE_W-1:0] OWNER_BUDGET_RST = BYTE_W'(64'd67108864);

    // One request as it travels from the input register to the accounting stage.
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic              present;
        logic              slot_ok;
        logic [BYTE_W-1:0] amount;
    } req_t;

endpackage

>>> rtl/core/bba_owner_ram.sv
// ----------------------------------------------------------------------------
// bba_owner_ram
// Owner usage table: one write port, one read port, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bba_owner_ram
    import bba_pkg::*;
#(
    parameter int DEPTH  = OWNER_SLOTS_DEF,
    parameter int ADDR_W = 6,
    parameter int DATA_W = BYTE_W
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bba_clear_seq.sv
// ----------------------------------------------------------------------------
// bba_clear_seq
// Clearing pass after reset: walks the owner table one entry per cycle and
// keeps the block busy until every entry has been written with zero.
// ----------------------------------------------------------------------------
module bba_clear_seq
    import bba_pkg::*;
#(
    parameter int DEPTH  = OWNER_SLOTS_DEF,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    output logic              active,
    output logic [ADDR_W-1:0] addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              active_reg;
    logic              active_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;

    // Advance through the table and stop after the last entry.
    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        if (active_reg)
        begin
            if (cnt_reg == LAST_ADDR)
            begin
                active_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign active = active_reg;
    assign addr   = cnt_reg;

endmodule

>>> rtl/core/bba_account.sv
// ----------------------------------------------------------------------------
// bba_account
// Accounting stage: takes a request together with the owner entry read from
// the table, decides admission, updates the totals, peak and spill counters,
// and writes the owner entry back. The last write is forwarded so that a
// request to the same owner in the next cycle sees the new value.
// ----------------------------------------------------------------------------
module bba_account
    import bba_pkg::*;
#(
    parameter int ADDR_W = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  req_t               req,
    input  logic [ADDR_W-1:0]  req_addr,
    input  logic [BYTE_W-1:0]  rd_data,
    input  logic [BYTE_W-1:0]  total_limit,
    input  logic [BYTE_W-1:0]  owner_budget,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [BYTE_W-1:0]  wr_data,
    output logic               done,
    output logic               granted,
    output logic [BYTE_W-1:0]  total_in_use,
    output logic [BYTE_W-1:0]  peak_in_use,
    output logic [BYTE_W-1:0]  owner_in_use,
    output logic [COUNT_W-1:0] spilled_total,
    output logic [COUNT_W-1:0] spill_fail_count
);

    // Running state.
    logic [BYTE_W-1:0]  total_reg;
    logic [BYTE_W-1:0]  total_next;
    logic [BYTE_W-1:0]  peak_reg;
    logic [BYTE_W-1:0]  peak_next;
    logic [COUNT_W-1:0] spill_reg;
    logic [COUNT_W-1:0] spill_next;
    logic [COUNT_W-1:0] fail_reg;
    logic [COUNT_W-1:0] fail_next;
    logic               done_reg;

    // Result payload.
    logic               granted_reg;
    logic               granted_next;
    logic [BYTE_W-1:0]  owner_out_reg;
    logic [BYTE_W-1:0]  owner_out_next;

    // Forwarding of the last owner write.
    logic               fwd_valid_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [BYTE_W-1:0]  fwd_data_reg;

    logic [BYTE_W-1:0]  held;
    logic [BYTE_W-1:0]  owner_new;
    logic [BYTE_W:0]    total_sum;
    logic [BYTE_W:0]    owner_sum;
    logic               fits;

    // Owner entry as of this request, with the previous write forwarded.
    assign held = (fwd_valid_reg && (fwd_addr_reg == req_addr)) ? fwd_data_reg : rd_data;

    // Budget checks on one-bit-wider sums.
    assign total_sum = {1'b0, total_reg} + {1'b0, req.amount};
    assign owner_sum = {1'b0, held} + {1'b0, req.amount};
    assign fits      = (total_sum <= {1'b0, total_limit})
                    && (owner_sum <= {1'b0, owner_budget});

    // Request decode and state update.
    always_comb
    begin
        total_next   = total_reg;
        spill_next   = spill_reg;
        fail_next    = fail_reg;
        owner_new    = held;
        granted_next = 1'b0;
        if (req_valid)
        begin
            unique case (req.opcode)
                OP_ACQUIRE:
                begin
                    if (req.present && req.slot_ok && fits)
                    begin
                        granted_next = 1'b1;
                        total_next   = total_sum[BYTE_W-1:0];
                        owner_new    = owner_sum[BYTE_W-1:0];
                    end
                end
                OP_RELEASE:
                begin
                    if (req.present)
                    begin
                        total_next = (req.amount > total_reg) ? '0 : total_reg - req.amount;
                        if (req.slot_ok)
                        begin
                            owner_new = (req.amount >= held) ? '0 : held - req.amount;
                        end
                    end
                end
                OP_SPILL:
                begin
                    spill_next = spill_reg + COUNT_W'(req.amount);
                end
                OP_SPILL_FAIL:
                begin
                    fail_next = fail_reg + COUNT_W'(1);
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end
        peak_next      = (total_next > peak_reg) ? total_next : peak_reg;
        owner_out_next = req.slot_ok ? owner_new : '0;
    end

    // Write the owner entry back whenever the slot exists.
    assign wr_en   = req_valid && req.slot_ok;
    assign wr_addr = req_addr;
    assign wr_data = owner_new;

    // Control and accounting state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            peak_reg      <= '0;
            spill_reg     <= '0;
            fail_reg      <= '0;
            done_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            peak_reg      <= peak_next;
            spill_reg     <= spill_next;
            fail_reg      <= fail_next;
            done_reg      <= req_valid;
            fwd_valid_reg <= wr_en;
        end
    end

    // Result payload and forwarded write.
    always_ff @(posedge clk)
    begin
        granted_reg   <= granted_next;
        owner_out_reg <= owner_out_next;
        fwd_addr_reg  <= wr_addr;
        fwd_data_reg  <= wr_data;
    end

    assign done             = done_reg;
    assign granted          = granted_reg;
    assign owner_in_use     = owner_out_reg;
    assign total_in_use     = total_reg;
    assign peak_in_use      = peak_reg;
    assign spilled_total    = spill_reg;
    assign spill_fail_count = fail_reg;

endmodule

>>> rtl/core/byte_budget_admission.sv
// ----------------------------------------------------------------------------
// byte_budget_admission
// Two-level byte budget admission: acquires are admitted against a global
// and a per-owner budget, releases give bytes back, spill notes are counted.
//
//   Channel   Signals                                          Direction
//   request   start, busy, opcode, owner_present,              in (busy out)
//             owner_index, amount
//   result    done, granted, total_in_use, peak_in_use,        out
//             owner_in_use, spilled_total, spill_fail_count
//   config    cfg_we, cfg_index, cfg_data                      in
//
// A transaction can be taken every cycle while busy is low; its result is
// registered by the accounting stage behind the request register, one result
// per request, in order. The owner table is read at the accepting edge and
// written back by the accounting stage, with the last write forwarded for
// back-to-back requests to the same owner. After reset a clearing pass zeroes
// the table; busy is high for that time. Results cannot be stalled.
// ----------------------------------------------------------------------------
module byte_budget_admission
    import bba_pkg::*;
#(
    parameter int OWNER_SLOTS = OWNER_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic               owner_present,
    input  logic [IDX_W-1:0]   owner_index,
    input  logic [BYTE_W-1:0]  amount,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]  cfg_data,
    output logic               done,
    output logic               granted,
    output logic [BYTE_W-1:0]  total_in_use,
    output logic [BYTE_W-1:0]  peak_in_use,
    output logic [BYTE_W-1:0]  owner_in_use,
    output logic [COUNT_W-1:0] spilled_total,
    output logic [COUNT_W-1:0] spill_fail_count
);

    localparam int ADDR_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    logic              accept;
    logic              clr_active;
    logic [ADDR_W-1:0] clr_addr;
    logic [EXT_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              slot_ok;

    logic [BYTE_W-1:0] total_limit_reg;
    logic [BYTE_W-1:0] owner_budget_reg;

    logic              req_valid_reg;
    req_t              req_reg;
    logic [ADDR_W-1:0] req_addr_reg;

    logic [BYTE_W-1:0] rd_data;
    logic              acc_wr_en;
    logic [ADDR_W-1:0] acc_wr_addr;
    logic [BYTE_W-1:0] acc_wr_data;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;

    // Request acceptance and table address.
    assign busy    = clr_active;
    assign accept  = start && !clr_active;
    assign idx_ext = EXT_W'(owner_index);
    assign rd_addr = idx_ext[ADDR_W-1:0];
    assign slot_ok = (32'(owner_index) < 32'(OWNER_SLOTS));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_limit_reg  <= TOTAL_LIMIT_RST;
            owner_budget_reg <= OWNER_BUDGET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL_LIMIT:  total_limit_reg  <= cfg_data;
                REG_OWNER_BUDGET: owner_budget_reg <= cfg_data;
                default:          total_limit_reg  <= total_limit_reg;
            endcase
        end
    end

    // Request register, aligned with the table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg.opcode  <= opcode;
        req_reg.present <= owner_present;
        req_reg.slot_ok <= slot_ok;
        req_reg.amount  <= amount;
        req_addr_reg    <= rd_addr;
    end

    // Table write port: the clearing pass owns it until it finishes.
    assign ram_we    = clr_active || acc_wr_en;
    assign ram_waddr = clr_active ? clr_addr : acc_wr_addr;
    assign ram_wdata = clr_active ? '0 : acc_wr_data;

    bba_clear_seq #(
        .DEPTH  (OWNER_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (clr_active),
        .addr   (clr_addr)
    );

    bba_owner_ram #(
        .DEPTH  (OWNER_SLOTS),
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr  (rd_addr),
        .rdata  (rd_data)
    );

    bba_account #(
        .ADDR_W (ADDR_W)
    ) u_account (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid_reg),
        .req              (req_reg),
        .req_addr         (req_addr_reg),
        .rd_data          (rd_data),
        .total_limit      (total_limit_reg),
        .owner_budget     (owner_budget_reg),
        .wr_en            (acc_wr_en),
        .wr_addr          (acc_wr_addr),
        .wr_data          (acc_wr_data),
        .done             (done),
        .granted          (granted),
        .total_in_use     (total_in_use),
        .peak_in_use      (peak_in_use),
        .owner_in_use     (owner_in_use),
        .spilled_total    (spilled_total),
        .spill_fail_count (spill_fail_count)
    );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for byte_budget_admission. A short table of directed
// requests covers the budget edges, absent owners, oversized releases and the
// spill notes. Random traffic then runs under several budget settings with
// different amounts of sender idling. A local ledger predicts every result,
// and each done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import bba_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_BYTES = {BYTE_W{1'b1}};
    localparam int                SLOTS     = OWNER_SLOTS_DEF;

    // One result as the block reports it.
    typedef struct packed {
        logic               granted;
        logic [BYTE_W-1:0]  total;
        logic [BYTE_W-1:0]  peak;
        logic [BYTE_W-1:0]  owner;
        logic [COUNT_W-1:0] spill;
        logic [COUNT_W-1:0] fails;
    } budget_result_t;

    // One row of the directed table.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              present;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] amt;
        logic              fixed;
        budget_result_t    outcome;
    } request_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    opcode;
    logic               owner_present;
    logic [IDX_W-1:0]   owner_index;
    logic [BYTE_W-1:0]  amount;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_index;
    logic [BYTE_W-1:0]  cfg_data;
    logic               done;
    logic               granted;
    logic [BYTE_W-1:0]  total_in_use;
    logic [BYTE_W-1:0]  peak_in_use;
    logic [BYTE_W-1:0]  owner_in_use;
    logic [COUNT_W-1:0] spilled_total;
    logic [COUNT_W-1:0] spill_fail_count;

    // Ledger that mirrors the block's accounting state and budgets.
    logic [BYTE_W-1:0]  cap_global;
    logic [BYTE_W-1:0]  cap_owner;
    logic [BYTE_W-1:0]  ledger_total;
    logic [BYTE_W-1:0]  ledger_peak;
    logic [COUNT_W-1:0] ledger_spill;
    logic [COUNT_W-1:0] ledger_fails;
    logic [BYTE_W-1:0]  ledger_owner [SLOTS];

    // Outcomes still owed by the block, oldest first.
    budget_result_t admission_outcomes [$];
    request_row_t   directed_rows [$];

    // Typed outcome that goes with the request on the bus, if any.
    logic           drv_fixed;
    budget_result_t drv_outcome;

    int mismatches;

    byte_budget_admission u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .owner_present    (owner_present),
        .owner_index      (owner_index),
        .amount           (amount),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .granted          (granted),
        .total_in_use     (total_in_use),
        .peak_in_use      (peak_in_use),
        .owner_in_use     (owner_in_use),
        .spilled_total    (spilled_total),
        .spill_fail_count (spill_fail_count)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #12000000;
        $display("FAIL byte_budget_admission");
        $finish;
    end

    // Applies one request to the ledger and returns what the block must report.
    function automatic budget_result_t apply_request(logic [OP_W-1:0] op, logic present,
                                                     logic [IDX_W-1:0] idx,
                                                     logic [BYTE_W-1:0] amt);
        budget_result_t r;
        logic [BYTE_W-1:0] held;
        logic ok;
        ok = 1'b0;
        held = ledger_owner[idx];
        if (op == OP_ACQUIRE)
        begin
            // Both budgets must have room; the compares avoid any overflow.
            if (present && amt <= cap_global && amt <= cap_owner &&
                ledger_total <= cap_global - amt && held <= cap_owner - amt)
            begin
                ok = 1'b1;
                ledger_total = ledger_total + amt;
                if (ledger_total > ledger_peak)
                    ledger_peak = ledger_total;
                ledger_owner[idx] = held + amt;
            end
        end
        else if (op == OP_RELEASE)
        begin
            // A release is clipped at zero on both levels.
            if (present)
            begin
                ledger_total = (amt > ledger_total) ? '0 : ledger_total - amt;
                ledger_owner[idx] = (amt >= held) ? '0 : held - amt;
            end
        end
        else if (op == OP_SPILL)
            ledger_spill = ledger_spill + COUNT_W'(amt);
        else
            ledger_fails = ledger_fails + COUNT_W'(1);
        r.granted = ok;
        r.total = ledger_total;
        r.peak = ledger_peak;
        r.owner = ledger_owner[idx];
        r.spill = ledger_spill;
        r.fails = ledger_fails;
        return r;
    endfunction

    task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Scoreboard: results are checked first, then the accepted transaction is
    // predicted. Both sample pre-edge values.
    always @(posedge clk)
    begin : scoreboard
        budget_result_t want;
        budget_result_t pred;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (admission_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, actual total %h",
                             $time, total_in_use);
                end
                else
                begin
                    want = admission_outcomes.pop_front();
                    check_field("granted", COUNT_W'(want.granted), COUNT_W'(granted));
                    check_field("total_in_use", COUNT_W'(want.total), COUNT_W'(total_in_use));
                    check_field("peak_in_use", COUNT_W'(want.peak), COUNT_W'(peak_in_use));
                    check_field("owner_in_use", COUNT_W'(want.owner), COUNT_W'(owner_in_use));
                    check_field("spilled_total", want.spill, spilled_total);
                    check_field("spill_fail_count", want.fails, spill_fail_count);
                end
            end
            if (start && !busy)
            begin
                pred = apply_request(opcode, owner_present, owner_index, amount);
                admission_outcomes.push_back(drv_fixed ? drv_outcome : pred);
            end
        end
    end

    // Drives one transaction after a random number of idle cycles and returns
    // at the edge that accepts it.
    task automatic issue_request(logic [OP_W-1:0] op, logic present, logic [IDX_W-1:0] idx,
                                 logic [BYTE_W-1:0] amt, logic fixed, budget_result_t outcome,
                                 int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        opcode = op;
        owner_present = present;
        owner_index = idx;
        amount = amt;
        drv_fixed = fixed;
        drv_outcome = outcome;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Holds the request side off until every outcome has come back.
    task automatic drain_requests();
        @(negedge clk);
        start = 1'b0;
        while (admission_outcomes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes one budget register while the block is idle.
    task automatic write_budget(logic [CFG_W-1:0] idx, logic [BYTE_W-1:0] value);
        drain_requests();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        if (idx == REG_TOTAL_LIMIT)
            cap_global = value;
        else
            cap_owner = value;
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(negedge clk);
    endtask

    task automatic add_row(logic [OP_W-1:0] op, logic present, logic [IDX_W-1:0] idx,
                           logic [BYTE_W-1:0] amt, logic fixed, logic g,
                           logic [BYTE_W-1:0] t, logic [BYTE_W-1:0] p, logic [BYTE_W-1:0] o,
                           logic [COUNT_W-1:0] s, logic [COUNT_W-1:0] f);
        request_row_t row;
        row.op = op;
        row.present = present;
        row.idx = idx;
        row.amt = amt;
        row.fixed = fixed;
        row.outcome = '{g, t, p, o, s, f};
        directed_rows.push_back(row);
    endtask

    // Amount biased toward the owner budget, with zero, all ones and full range.
    function automatic logic [BYTE_W-1:0] pick_amount();
        logic [63:0] r;
        logic [BYTE_W-1:0] lim;
        int unsigned pick;
        r = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        lim = cap_owner >> 2;
        if (pick < 8)
            return '0;
        else if (pick < 14)
            return MAX_BYTES;
        else if (pick < 20)
            return cap_owner;
        else if (pick < 30)
            return r[BYTE_W-1:0];
        return BYTE_W'(r % ({16'd0, lim} + 64'd1));
    endfunction

    // Random traffic; most requests go to a few owners so budgets fill up and
    // back-to-back requests hit the same table entry.
    task automatic random_traffic(int count, int idle_pct);
        logic [OP_W-1:0] op;
        logic [IDX_W-1:0] idx;
        int unsigned pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = OP_ACQUIRE;
            else if (pick < 70)
                op = OP_RELEASE;
            else if (pick < 85)
                op = OP_SPILL;
            else
                op = OP_SPILL_FAIL;
            if ($urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, 7));
            else
                idx = IDX_W'($urandom_range(0, SLOTS - 1));
            issue_request(op, $urandom_range(0, 9) != 0, idx, pick_amount(), 1'b0, '0,
                          idle_pct);
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ACQUIRE;
        owner_present = 1'b0;
        owner_index = '0;
        amount = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TOTAL_LIMIT;
        cfg_data = '0;
        drv_fixed = 1'b0;
        drv_outcome = '0;
        mismatches = 0;
        cap_global = TOTAL_LIMIT_RST;
        cap_owner = OWNER_BUDGET_RST;
        ledger_total = '0;
        ledger_peak = '0;
        ledger_spill = '0;
        ledger_fails = '0;
        for (int i = 0; i < SLOTS; i++)
            ledger_owner[i] = '0;

        // Directed table at the reset budgets (256 MiB total, 64 MiB per owner).
        // Zero-byte acquire, then fill owner 63 to its budget exactly.
        add_row(OP_ACQUIRE, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0);
        add_row(OP_ACQUIRE, 1, 63, 48'h400_0000, 1, 1,
                48'h400_0000, 48'h400_0000, 48'h400_0000, 0, 0);
        // One byte over the owner budget, an amount over both, an absent owner.
        add_row(OP_ACQUIRE, 1, 63, 1, 1, 0, 48'h400_0000, 48'h400_0000, 48'h400_0000, 0, 0);
        add_row(OP_ACQUIRE, 1, 1, MAX_BYTES, 1, 0, 48'h400_0000, 48'h400_0000, 0, 0, 0);
        add_row(OP_ACQUIRE, 0, 2, 5, 1, 0, 48'h400_0000, 48'h400_0000, 0, 0, 0);
        // Fill the global budget exactly, then one byte more is refused.
        add_row(OP_ACQUIRE, 1, 1, 48'h400_0000, 1, 1,
                48'h800_0000, 48'h800_0000, 48'h400_0000, 0, 0);
        add_row(OP_ACQUIRE, 1, 2, 48'h400_0000, 1, 1,
                48'hC00_0000, 48'hC00_0000, 48'h400_0000, 0, 0);
        add_row(OP_ACQUIRE, 1, 3, 48'h400_0000, 1, 1,
                48'h1000_0000, 48'h1000_0000, 48'h400_0000, 0, 0);
        add_row(OP_ACQUIRE, 1, 4, 1, 1, 0, 48'h1000_0000, 48'h1000_0000, 0, 0, 0);
        // Release with an absent owner changes nothing.
        add_row(OP_RELEASE, 0, 3, 48'h1000, 1, 0,
                48'h1000_0000, 48'h1000_0000, 48'h400_0000, 0, 0);
        // Oversized release clips the owner entry; release by an empty owner.
        add_row(OP_RELEASE, 1, 3, 48'h500_0000, 1, 0, 48'hB00_0000, 48'h1000_0000, 0, 0, 0);
        add_row(OP_RELEASE, 1, 5, 48'h1000, 1, 0, 48'hAFF_F000, 48'h1000_0000, 0, 0, 0);
        // Spill notes ignore the owner fields but still report the slot.
        add_row(OP_SPILL, 0, 0, MAX_BYTES, 1, 0,
                48'hAFF_F000, 48'h1000_0000, 0, 64'h0000_FFFF_FFFF_FFFF, 0);
        add_row(OP_SPILL_FAIL, 1, 63, 48'h123, 1, 0,
                48'hAFF_F000, 48'h1000_0000, 48'h400_0000, 64'h0000_FFFF_FFFF_FFFF, 1);
        // Oversized release clips the total at zero.
        add_row(OP_RELEASE, 1, 1, MAX_BYTES, 1, 0,
                0, 48'h1000_0000, 0, 64'h0000_FFFF_FFFF_FFFF, 1);
        // Repeated requests to one owner, checked by the ledger.
        add_row(OP_ACQUIRE, 1, 42, 48'h3000, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_ACQUIRE, 1, 42, 48'h1000, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_RELEASE, 1, 42, 48'h800, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_ACQUIRE, 1, 42, 48'h400_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_SPILL, 1, 42, 1, 0, 0, 0, 0, 0, 0, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            issue_request(directed_rows[i].op, directed_rows[i].present, directed_rows[i].idx,
                          directed_rows[i].amt, directed_rows[i].fixed,
                          directed_rows[i].outcome, 20);

        // Small budgets so that grants and refusals mix.
        write_budget(REG_TOTAL_LIMIT, 48'h2_0000);
        write_budget(REG_OWNER_BUDGET, 48'h8000);
        random_traffic(220, 20);
        drain_requests();
        random_traffic(230, 20);

        // Both budgets zero: only zero-byte acquires pass.
        write_budget(REG_TOTAL_LIMIT, '0);
        write_budget(REG_OWNER_BUDGET, '0);
        random_traffic(60, 20);

        // Both budgets at their largest.
        write_budget(REG_TOTAL_LIMIT, MAX_BYTES);
        write_budget(REG_OWNER_BUDGET, MAX_BYTES);
        random_traffic(150, 88);

        // Owner budget above the global one.
        write_budget(REG_TOTAL_LIMIT, 48'h6000);
        random_traffic(200, 88);

        // Back-to-back traffic with no idling.
        write_budget(REG_TOTAL_LIMIT, 48'h4_0000);
        write_budget(REG_OWNER_BUDGET, 48'h3000);
        random_traffic(490, 0);

        // Let the pipeline empty and watch for stray results.
        drain_requests();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("PASS byte_budget_admission");
        else
            $display("FAIL byte_budget_admission");
        $finish;
    end

endmodule
